// ===== sv/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, S-box tables and round functions of the AES cipher core.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  typedef logic [127:0] blk_t;
  typedef logic [31:0]  word_t;

  // Round-key memories hold one 128-bit round key per row.
  localparam int RK_ROWS = 15;
  localparam int ROW_W   = 4;

  // Key length codes of the key_length register.
  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;
  localparam logic [1:0] KLEN_256 = 2'd2;
  localparam logic [1:0] KLEN_BAD = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [2:0] REG_KEY_BITS_0 = 3'd1;
  localparam logic [2:0] REG_KEY_BITS_1 = 3'd2;
  localparam logic [2:0] REG_KEY_BITS_2 = 3'd3;
  localparam logic [2:0] REG_KEY_BITS_3 = 3'd4;

  // One row write from the key expansion into both key memories.
  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] row;
    blk_t             enc;
    blk_t             dec;
  } kx_wr_t;

  localparam logic [0:255][7:0] SBOX = {
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [0:255][7:0] INV_SBOX = {
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // Multiply by x in GF(2^8) modulo 0x11B.
  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic word_t sub_word(input word_t w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic word_t mix_col(input word_t w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24];
    a1 = w[23:16];
    a2 = w[15:8];
    a3 = w[7:0];
    return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
            xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  function automatic word_t inv_mix_col(input word_t w);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] x2, x4, x8;
    for (int k = 0; k < 4; k++) begin
      a[k]  = w[31-8*k -: 8];
      x2    = xt(a[k]);
      x4    = xt(x2);
      x8    = xt(x4);
      m9[k] = x8 ^ a[k];
      mb[k] = x8 ^ x2 ^ a[k];
      md[k] = x8 ^ x4 ^ a[k];
      me[k] = x8 ^ x4 ^ x2;
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  // One forward round without the key addition.
  function automatic blk_t enc_round(input blk_t s, input logic last);
    logic [7:0] a [16];
    logic [7:0] t [16];
    blk_t  o;
    word_t w;
    for (int k = 0; k < 16; k++) a[k] = SBOX[s[127-8*k -: 8]];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[4*c+r] = a[4*((c+r)&3)+r];
    for (int c = 0; c < 4; c++) begin
      w = {t[4*c], t[4*c+1], t[4*c+2], t[4*c+3]};
      o[127-32*c -: 32] = last ? w : mix_col(w);
    end
    return o;
  endfunction

  // One equivalent-inverse round without the key addition.
  function automatic blk_t dec_round(input blk_t s, input logic last);
    logic [7:0] a [16];
    logic [7:0] t [16];
    blk_t  o;
    word_t w;
    for (int k = 0; k < 16; k++) a[k] = INV_SBOX[s[127-8*k -: 8]];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[4*c+r] = a[4*((c+4-r)&3)+r];
    for (int c = 0; c < 4; c++) begin
      w = {t[4*c], t[4*c+1], t[4*c+2], t[4*c+3]};
      o[127-32*c -: 32] = last ? w : inv_mix_col(w);
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== sv/aes_ram.sv =====
// ----------------------------------------------------------------------------
// aes_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/aes_key_exp.sv =====
// ----------------------------------------------------------------------------
// aes_key_exp
// Key expansion: one schedule word per cycle, written as rows of four words
// into the encryption and equivalent-inverse key memories.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_key_exp
  import aes_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [1:0]   key_len,
  input  wire logic [255:0] key,
  output      logic         done,
  output      kx_wr_t       wr
);

  logic         act_r, act_nxt;
  logic [5:0]   idx_r, idx_nxt;
  logic [2:0]   ph_r, ph_nxt;
  logic [7:0]   rc_r, rc_nxt;
  word_t        win_r [8];
  logic [95:0]  row_e_r, row_d_r;

  logic [3:0]   nk, nr;
  logic [5:0]   total;
  logic [2:0]   nk_m1;
  word_t        prev, tw, nw, dw;
  logic [3:0]   row;

  always_comb begin
    case (key_len)
      KLEN_192: nk = 4'd6;
      KLEN_256: nk = 4'd8;
      default:  nk = 4'd4;
    endcase
    nr    = nk + 4'd6;
    total = {nr, 2'b00} + 6'd4;
    nk_m1 = 3'(nk - 4'd1);
    prev  = win_r[0];
    if (ph_r == 3'd0) begin
      tw = sub_word({prev[23:0], prev[31:24]}) ^ {rc_r, 24'd0};
    end else if (nk == 4'd8 && ph_r == 3'd4) begin
      tw = sub_word(prev);
    end else begin
      tw = prev;
    end
    if ({1'b0, idx_r} < {3'd0, nk}) begin
      nw = key[255 - 32*idx_r[2:0] -: 32];
    end else begin
      nw = win_r[nk_m1] ^ tw;
    end
    row = idx_r[5:2];
    dw  = (row != 4'd0 && row < nr) ? inv_mix_col(nw) : nw;
  end

  assign done   = act_r && (idx_r == total - 6'd1);
  assign wr.we  = act_r && (idx_r[1:0] == 2'd3);
  assign wr.row = row;
  assign wr.enc = {row_e_r, nw};
  assign wr.dec = {row_d_r, dw};

  always_comb begin
    act_nxt = act_r;
    idx_nxt = idx_r;
    ph_nxt  = ph_r;
    rc_nxt  = rc_r;
    if (start) begin
      act_nxt = 1'b1;
      idx_nxt = 6'd0;
      ph_nxt  = 3'd0;
      rc_nxt  = 8'h01;
    end else if (act_r) begin
      idx_nxt = idx_r + 6'd1;
      ph_nxt  = (ph_r == nk_m1) ? 3'd0 : ph_r + 3'd1;
      if (ph_r == 3'd0 && {1'b0, idx_r} >= {3'd0, nk}) begin
        rc_nxt = xt(rc_r);
      end
      if (done) begin
        act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      idx_r <= 6'd0;
      ph_r  <= 3'd0;
      rc_r  <= 8'h01;
    end else begin
      act_r <= act_nxt;
      idx_r <= idx_nxt;
      ph_r  <= ph_nxt;
      rc_r  <= rc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (act_r) begin
      win_r[0] <= nw;
      for (int k = 1; k < 8; k++) win_r[k] <= win_r[k-1];
      row_e_r <= {row_e_r[63:0], nw};
      row_d_r <= {row_d_r[63:0], dw};
    end
  end

endmodule

`default_nettype wire

// ===== sv/aes_block_cipher.sv =====
// ----------------------------------------------------------------------------
// aes_block_cipher
// AES-128/192/256 encrypt and decrypt core with round keys kept in memory.
// ----------------------------------------------------------------------------
// Usage:
// The cfg channel writes key_length (index 0) and the four 64-bit key words
// (indexes 1 to 4); it is always ready. Any such write marks the key schedule
// stale. Configuration must be written only while the core is idle; the
// core itself does not enforce this. An input item carries an operation bit
// (0 encrypt, 1 decrypt) and a 128-bit block. The core works on one item at
// a time: in_ready is high only while it is idle. If the schedule is stale,
// the item first waits while the key expansion writes one word per cycle into
// two round-key memories (44, 52 or 60 words for 128, 192 or 256-bit keys).
// The encryption memory holds the plain round keys; the decryption memory
// holds the equivalent-inverse keys. Each block then passes through an issue
// state, a whitening state and Nr rounds (10, 12 or 14) on the shared round
// unit, whose pace is set by one key-memory read per round, and a done state
// that moves it into the output register and raises out_valid. The result
// waits in the output register until taken; if the receiver stalls, the
// finished block is held internally and no new item is taken. Synchronous
// reset clears the configuration registers, the control state and the
// schedule flag; the key memories are rebuilt before the first block.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_block_cipher
  import aes_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        in_operation,
  input  wire logic [63:0] in_block_high,
  input  wire logic [63:0] in_block_low,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [63:0] out_result_high,
  output      logic [63:0] out_result_low
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXPAND = 3'd1;
  localparam logic [2:0] S_ISSUE  = 3'd2;
  localparam logic [2:0] S_KEY0   = 3'd3;
  localparam logic [2:0] S_ROUND  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]   st_r, st_nxt;
  logic [1:0]   klen_r;
  logic [63:0]  key_r [4];
  logic         sched_ok_r, sched_ok_nxt;
  logic         op_r;
  blk_t         blk_r, blk_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic         outv_r, outv_nxt;
  blk_t         out_r;

  logic         cfg_fire, in_fire, out_free;
  logic         kx_start, kx_done;
  kx_wr_t       kx_wr;
  logic [3:0]   nr;
  logic [3:0]   step;
  logic [3:0]   rd_row;
  logic         rd_en;
  logic         last;
  blk_t         enc_key, dec_key, rkey, rnd_out;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = (st_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = outv_r;
  assign out_result_high = out_r[127:64];
  assign out_result_low  = out_r[63:0];
  assign out_free  = !outv_r || out_ready;

  always_comb begin
    case (klen_r)
      KLEN_192: nr = 4'd12;
      KLEN_256: nr = 4'd14;
      default:  nr = 4'd10;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= KLEN_128;
      for (int k = 0; k < 4; k++) key_r[k] <= 64'd0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_KEY_LENGTH: if (cfg_data[1:0] != KLEN_BAD) klen_r <= cfg_data[1:0];
        REG_KEY_BITS_0: key_r[0] <= cfg_data;
        REG_KEY_BITS_1: key_r[1] <= cfg_data;
        REG_KEY_BITS_2: key_r[2] <= cfg_data;
        REG_KEY_BITS_3: key_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  aes_key_exp u_kx (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (kx_start),
    .key_len (klen_r),
    .key     ({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .done    (kx_done),
    .wr      (kx_wr)
  );

  aes_ram #(.WIDTH(128), .DEPTH(RK_ROWS)) u_enc_ram (
    .clk   (clk),
    .we    (kx_wr.we),
    .waddr (kx_wr.row),
    .wdata (kx_wr.enc),
    .re    (rd_en),
    .raddr (rd_row),
    .rdata (enc_key)
  );

  aes_ram #(.WIDTH(128), .DEPTH(RK_ROWS)) u_dec_ram (
    .clk   (clk),
    .we    (kx_wr.we),
    .waddr (kx_wr.row),
    .wdata (kx_wr.dec),
    .re    (rd_en),
    .raddr (rd_row),
    .rdata (dec_key)
  );

  // Row read for the next round: ascending for encryption, descending for
  // decryption. The last round issues no read.
  assign last = (rnd_r == nr);
  always_comb begin
    case (st_r)
      S_ISSUE: step = 4'd0;
      S_KEY0:  step = 4'd1;
      default: step = rnd_r + 4'd1;
    endcase
    rd_row = op_r ? nr - step : step;
    rd_en  = (st_r == S_ISSUE) || (st_r == S_KEY0) || (st_r == S_ROUND && !last);
  end

  assign rkey    = op_r ? dec_key : enc_key;
  assign rnd_out = op_r ? dec_round(blk_r, last) : enc_round(blk_r, last);

  always_comb begin
    st_nxt       = st_r;
    sched_ok_nxt = sched_ok_r;
    blk_nxt      = blk_r;
    rnd_nxt      = rnd_r;
    outv_nxt     = outv_r;
    kx_start     = 1'b0;
    if (outv_r && out_ready) begin
      outv_nxt = 1'b0;
    end
    if (cfg_fire && cfg_index <= REG_KEY_BITS_3) begin
      sched_ok_nxt = 1'b0;
    end
    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          blk_nxt = {in_block_high, in_block_low};
          if (sched_ok_r) begin
            st_nxt = S_ISSUE;
          end else begin
            st_nxt   = S_EXPAND;
            kx_start = 1'b1;
          end
        end
      end
      S_EXPAND: begin
        if (kx_done) begin
          sched_ok_nxt = 1'b1;
          st_nxt       = S_ISSUE;
        end
      end
      S_ISSUE: begin
        st_nxt = S_KEY0;
      end
      S_KEY0: begin
        blk_nxt = blk_r ^ rkey;
        rnd_nxt = 4'd1;
        st_nxt  = S_ROUND;
      end
      S_ROUND: begin
        blk_nxt = rnd_out ^ rkey;
        rnd_nxt = rnd_r + 4'd1;
        if (last) begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          outv_nxt = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      sched_ok_r <= 1'b0;
      outv_r     <= 1'b0;
      rnd_r      <= 4'd0;
    end else begin
      st_r       <= st_nxt;
      sched_ok_r <= sched_ok_nxt;
      outv_r     <= outv_nxt;
      rnd_r      <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    if (in_fire) begin
      op_r <= in_operation;
    end
    if (st_r == S_DONE && out_free) begin
      out_r <= blk_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_key_write_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_KEY0 || st_r == S_ROUND) |-> !kx_wr.we)
    else $error("key memory written while a block is in progress");

  a_stale_expands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !sched_ok_r) |=> st_r == S_EXPAND)
    else $error("stale schedule not expanded before the block");

  a_expand_marks_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EXPAND && kx_done) |=> sched_ok_r)
    else $error("schedule flag not set after expansion");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ROUND) |-> (rnd_r >= 4'd1 && rnd_r <= nr))
    else $error("round counter out of range");
`endif

endmodule

`default_nettype wire
